[rtl/arpc_pkg.sv]
// types, constants and register codes shared by the arp cache and responder
// depends on nothing; the core, arpc_cfg and the bench import it
package arpc_pkg;

    // defaults for the top-level parameters
    localparam int DEF_CACHE_ENTRIES = 16;
    localparam int DEF_NUM_IFACES    = 3;

    // field widths
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int HALF_W  = 16;
    localparam int IFACE_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IFACES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IF0_IP  = 3'd0,
        CFG_IF0_MAC = 3'd1,
        CFG_IF1_IP  = 3'd2,
        CFG_IF1_MAC = 3'd3,
        CFG_IF2_IP  = 3'd4,
        CFG_IF2_MAC = 3'd5,
        CFG_IF_EN   = 3'd6
    } t_cfg_idx;

    localparam t_cfg_idx CFG_IP_IDX [CFG_IFACES] = '{CFG_IF0_IP, CFG_IF1_IP, CFG_IF2_IP};
    localparam t_cfg_idx CFG_MAC_IDX [CFG_IFACES] = '{CFG_IF0_MAC, CFG_IF1_MAC, CFG_IF2_MAC};

    // request kinds and protocol constants
    localparam logic              REQ_LOOKUP   = 1'b0;
    localparam logic              REQ_PACKET   = 1'b1;
    localparam logic [HALF_W-1:0] MIN_ARP_LEN  = 16'd28;
    localparam logic [HALF_W-1:0] OPER_REQUEST = 16'd1;

    // contents of entry 0 after reset
    localparam logic [IP_W-1:0]  E0_IP  = 32'h0A00_0202;
    localparam logic [MAC_W-1:0] E0_MAC = {8'h52, 8'h54, 8'h00, 8'h12, 8'h34, 8'h56};

    typedef struct packed {
        logic              req_type;
        logic [IP_W-1:0]   lookup_ip;
        logic [HALF_W-1:0] pkt_len;
        logic [HALF_W-1:0] pkt_oper;
        logic [HALF_W-1:0] pkt_htype;
        logic [HALF_W-1:0] pkt_ptype;
        logic [MAC_W-1:0]  pkt_sender_mac;
        logic [IP_W-1:0]   pkt_sender_ip;
        logic [IP_W-1:0]   pkt_target_ip;
    } t_arp_req;

    typedef struct packed {
        logic               lookup_hit;
        logic [MAC_W-1:0]   lookup_mac;
        logic               reply_valid;
        logic [IFACE_W-1:0] reply_iface;
        logic [MAC_W-1:0]   reply_sender_mac;
        logic [IP_W-1:0]    reply_sender_ip;
        logic [MAC_W-1:0]   reply_target_mac;
        logic [IP_W-1:0]    reply_target_ip;
        logic [HALF_W-1:0]  reply_htype;
        logic [HALF_W-1:0]  reply_ptype;
    } t_arp_rsp;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_entry;

endpackage

[rtl/arpc_stream_if.sv]
// valid/ready channel carrying one word of a given payload type
// depends on nothing; the payload type is set where the channel is declared
interface arpc_stream_if #(
    parameter type T_DATA = logic
) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/arp_cache_and_responder_core.sv]
// Resolves IPv4 addresses from a small cache and answers ARP requests aimed at
// a local interface. One word is taken at a time and gives exactly one result
// word; the input is not ready until that result has been taken. The table is
// a single-port memory scanned one entry per cycle through one 32-bit
// comparator, and the same comparator then checks the interfaces one by one.
// A lookup scans entries until the first hit, at most CACHE_ENTRIES of them; a
// learned packet scans for a free or matching slot, then writes it and, for a
// request, checks up to NUM_IFACES interfaces; a packet under 28 bytes skips
// the scan and the write. The result is then held until taken.
// Entry 0 comes out of reset holding 10.0.2.2 / 52:54:00:12:34:56; no clearing
// pass is needed.
// depends on arpc_pkg, arpc_stream_if and arpc_cfg
module arp_cache_and_responder_core
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int NUM_IFACES    = DEF_NUM_IFACES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    arpc_stream_if.sink           i_req,
    arpc_stream_if.source         o_rsp
);

    localparam int IW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW  = $clog2(CACHE_ENTRIES + 1);
    localparam int IFW = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_IFACE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_arp_req          r_item, n_item;
    t_arp_rsp          r_res, n_res;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]     r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]     r_wr_idx, n_wr_idx;
    logic [IFW-1:0]    r_if, n_if;

    t_entry            r_mem [CACHE_ENTRIES];
    t_entry            r_rd_q;
    logic              r_rd_dflt;
    logic              r_e0_dflt;
    logic              r_valid [CACHE_ENTRIES];

    logic              rd_en;
    logic              wr_en;
    logic [IW-1:0]     rd_addr;
    logic [IP_W-1:0]   ent_ip;
    logic [MAC_W-1:0]  ent_mac;
    logic [IP_W-1:0]   key_ip;
    logic [IP_W-1:0]   cmp_a;
    logic [IP_W-1:0]   cmp_b;
    logic              cmp_eq;
    logic              last_cmp;
    logic [IP_W-1:0]   sel_ip;
    logic [MAC_W-1:0]  sel_mac;
    logic              sel_en;

    // interface registers
    arpc_cfg #(
        .NUM_IFACES (NUM_IFACES),
        .IFW        (IFW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sel       (r_if),
        .o_sel_ip    (sel_ip),
        .o_sel_mac   (sel_mac),
        .o_sel_en    (sel_en)
    );

    // table memory, one read or one write a cycle
    assign rd_addr = r_rd_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_idx] <= '{ip: r_item.pkt_sender_ip, mac: r_item.pkt_sender_mac};
        end
        if (rd_en) begin
            r_rd_q    <= r_mem[rd_addr];
            r_rd_dflt <= r_e0_dflt && (rd_addr == '0);
        end
    end

    // entry 0 reads its reset contents until first overwritten
    assign ent_ip  = r_rd_dflt ? E0_IP  : r_rd_q.ip;
    assign ent_mac = r_rd_dflt ? E0_MAC : r_rd_q.mac;

    // valid bits and the entry 0 reset flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < CACHE_ENTRIES; e++) begin
                r_valid[e] <= (e == 0);
            end
            r_e0_dflt <= 1'b1;
        end else if (wr_en) begin
            r_valid[r_wr_idx] <= 1'b1;
            if (r_wr_idx == '0) begin
                r_e0_dflt <= 1'b0;
            end
        end
    end

    // shared comparator: table scan, then interface checks
    assign key_ip   = (r_item.req_type == REQ_LOOKUP) ? r_item.lookup_ip : r_item.pkt_sender_ip;
    assign cmp_a    = (r_state == S_IFACE) ? sel_ip : ent_ip;
    assign cmp_b    = (r_state == S_IFACE) ? r_item.pkt_target_ip : key_ip;
    assign cmp_eq   = (cmp_a == cmp_b);
    assign last_cmp = (r_cmp_idx == IW'(CACHE_ENTRIES - 1));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_res     = r_res;
        n_rd_idx  = r_rd_idx;
        n_cmp_vld = r_cmp_vld;
        n_cmp_idx = r_cmp_idx;
        n_wr_idx  = r_wr_idx;
        n_if      = r_if;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_item    = i_req.data;
                    n_res     = '0;
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    if (i_req.data.req_type == REQ_PACKET &&
                        i_req.data.pkt_len < MIN_ARP_LEN) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while comparing the previous one
                if (r_rd_idx < CW'(CACHE_ENTRIES)) begin
                    rd_en     = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = rd_addr;
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld) begin
                    if (r_item.req_type == REQ_LOOKUP) begin
                        if (r_valid[r_cmp_idx] && cmp_eq) begin
                            n_res.lookup_hit = 1'b1;
                            n_res.lookup_mac = ent_mac;
                            n_state          = S_DONE;
                        end else if (last_cmp) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        // first free or matching slot; a full table takes entry 0
                        if (!r_valid[r_cmp_idx] || cmp_eq) begin
                            n_wr_idx = r_cmp_idx;
                            n_state  = S_WRITE;
                        end else if (last_cmp) begin
                            n_wr_idx = '0;
                            n_state  = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                wr_en = 1'b1;
                if (r_item.pkt_oper == OPER_REQUEST) begin
                    n_if    = '0;
                    n_state = S_IFACE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_IFACE: begin
                if (sel_en && cmp_eq) begin
                    n_res.reply_valid      = 1'b1;
                    n_res.reply_iface      = IFACE_W'(r_if);
                    n_res.reply_sender_mac = sel_mac;
                    n_res.reply_sender_ip  = r_item.pkt_target_ip;
                    n_res.reply_target_mac = r_item.pkt_sender_mac;
                    n_res.reply_target_ip  = r_item.pkt_sender_ip;
                    n_res.reply_htype      = r_item.pkt_htype;
                    n_res.reply_ptype      = r_item.pkt_ptype;
                    n_state                = S_DONE;
                end else if (r_if == IFW'(NUM_IFACES - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_if = r_if + 1'b1;
                end
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_res     <= n_res;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_wr_idx  <= n_wr_idx;
        r_if      <= n_if;
    end

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_DONE);
    assign o_rsp.data  = r_res;

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("input ready while a result word is pending");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.data.lookup_hit && o_rsp.data.reply_valid))
        else $error("result word carries both a hit and a reply");

    a_entry0_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0])
        else $error("entry 0 lost its valid bit");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ready |=> !o_rsp.valid && i_req.ready)
        else $error("result word not retired after being taken");

    a_write_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> $past(r_state == S_SCAN) && r_item.req_type == REQ_PACKET)
        else $error("table written outside a learn");

endmodule

[rtl/arpc_cfg.sv]
// interface register file: address, mac and enable of each local interface
// depends on arpc_pkg for register codes and widths
module arpc_cfg
    import arpc_pkg::*;
#(
    parameter int NUM_IFACES = DEF_NUM_IFACES,
    parameter int IFW        = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [IFW-1:0]        i_sel,
    output logic [IP_W-1:0]       o_sel_ip,
    output logic [MAC_W-1:0]      o_sel_mac,
    output logic                  o_sel_en
);

    logic [IP_W-1:0]       r_ip  [NUM_IFACES];
    logic [MAC_W-1:0]      r_mac [NUM_IFACES];
    logic [NUM_IFACES-1:0] r_en;

    // register writes; codes beyond the list and absent interfaces are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_IFACES; g++) begin
                r_ip[g]  <= '0;
                r_mac[g] <= '0;
            end
            r_en <= '0;
        end else if (i_cfg_wr_en) begin
            for (int g = 0; g < NUM_IFACES; g++) begin
                if (i_cfg_index == CFG_IP_IDX[g]) begin
                    r_ip[g] <= i_cfg_wdata[IP_W-1:0];
                end
                if (i_cfg_index == CFG_MAC_IDX[g]) begin
                    r_mac[g] <= i_cfg_wdata[MAC_W-1:0];
                end
            end
            if (i_cfg_index == CFG_IF_EN) begin
                r_en <= i_cfg_wdata[NUM_IFACES-1:0];
            end
        end
    end

    // one interface presented to the responder at a time
    assign o_sel_ip  = r_ip[i_sel];
    assign o_sel_mac = r_mac[i_sel];
    assign o_sel_en  = r_en[i_sel];

endmodule

[bench/tb.sv]
// testbench for arp_cache_and_responder_core: directed table then random words
// with its own cache/interface predictor; needs arpc_pkg, arpc_stream_if and the core
`timescale 1ns / 1ps

module tb
    import arpc_pkg::*;
();

    localparam int N_ENTRIES   = DEF_CACHE_ENTRIES;
    localparam int N_IFACES    = DEF_NUM_IFACES;
    localparam int PHASES      = 5;
    localparam int PHASE_WORDS = 246;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS  = 6_000_000;
    localparam int POOL_SIZE   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic [HALF_W-1:0]    OPER_REPLY    = 16'd2;
    localparam logic [HALF_W-1:0]    HTYPE_ETH     = 16'd1;
    localparam logic [HALF_W-1:0]    PTYPE_IPV4    = 16'h0800;
    localparam t_arp_rsp             NO_ANSWER     = '0;

    typedef struct {
        t_arp_req req;
        logic     given;
        t_arp_rsp rsp;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    arpc_stream_if #(.T_DATA(t_arp_req)) req_if ();
    arpc_stream_if #(.T_DATA(t_arp_rsp)) rsp_if ();

    arp_cache_and_responder_core #(
        .CACHE_ENTRIES(N_ENTRIES),
        .NUM_IFACES   (N_IFACES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // predictor state: cache table and interface registers
    logic [IP_W-1:0]  tbl_ip    [N_ENTRIES];
    logic [MAC_W-1:0] tbl_mac   [N_ENTRIES];
    logic             tbl_valid [N_ENTRIES];
    logic [IP_W-1:0]  if_ip     [CFG_IFACES];
    logic [MAC_W-1:0] if_mac    [CFG_IFACES];
    logic [2:0]       if_en;

    logic [IP_W-1:0] ip_pool [POOL_SIZE];
    t_arp_rsp        pending_answers [$];
    t_arp_rsp        want;
    t_arp_rsp        cur_given_rsp;
    logic            cur_given = 1'b0;
    logic            send_no_idle = 1'b0;
    logic            recv_no_idle = 1'b0;
    int              n_answers = 0;
    int              n_err = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("[arp_cache_and_responder_core] ERROR");
        $finish;
    end

    // resolve a lookup or learn a packet and work out any reply
    function automatic t_arp_rsp compute_answer(input t_arp_req r);
        t_arp_rsp a;
        int       slot;
        a = '0;
        if (r.req_type == REQ_LOOKUP) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (!a.lookup_hit && tbl_valid[i] && tbl_ip[i] == r.lookup_ip) begin
                    a.lookup_hit = 1'b1;
                    a.lookup_mac = tbl_mac[i];
                end
            end
            return a;
        end
        if (r.pkt_len < MIN_ARP_LEN)
            return a;
        // first free slot or one already holding the sender, else entry 0
        slot = -1;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (slot < 0 && (!tbl_valid[i] || tbl_ip[i] == r.pkt_sender_ip))
                slot = i;
        end
        if (slot < 0)
            slot = 0;
        tbl_ip[slot]    = r.pkt_sender_ip;
        tbl_mac[slot]   = r.pkt_sender_mac;
        tbl_valid[slot] = 1'b1;
        if (r.pkt_oper == OPER_REQUEST) begin
            for (int k = 0; k < N_IFACES; k++) begin
                if (!a.reply_valid && if_en[k] && if_ip[k] == r.pkt_target_ip) begin
                    a.reply_valid      = 1'b1;
                    a.reply_iface      = IFACE_W'(k);
                    a.reply_sender_mac = if_mac[k];
                    a.reply_sender_ip  = r.pkt_target_ip;
                    a.reply_target_mac = r.pkt_sender_mac;
                    a.reply_target_ip  = r.pkt_sender_ip;
                    a.reply_htype      = r.pkt_htype;
                    a.reply_ptype      = r.pkt_ptype;
                end
            end
        end
        return a;
    endfunction

    task automatic field_err(input string name, input logic [63:0] w, input logic [63:0] g);
        n_err++;
        $display("%0t: %s mismatch, expected %h got %h", $time, name, w, g);
    endtask

    task automatic check_answer(input t_arp_rsp w, input t_arp_rsp g);
        if (g.lookup_hit !== w.lookup_hit)
            field_err("lookup_hit", 64'(w.lookup_hit), 64'(g.lookup_hit));
        if (g.lookup_mac !== w.lookup_mac)
            field_err("lookup_mac", 64'(w.lookup_mac), 64'(g.lookup_mac));
        if (g.reply_valid !== w.reply_valid)
            field_err("reply_valid", 64'(w.reply_valid), 64'(g.reply_valid));
        if (g.reply_iface !== w.reply_iface)
            field_err("reply_iface", 64'(w.reply_iface), 64'(g.reply_iface));
        if (g.reply_sender_mac !== w.reply_sender_mac)
            field_err("reply_sender_mac", 64'(w.reply_sender_mac), 64'(g.reply_sender_mac));
        if (g.reply_sender_ip !== w.reply_sender_ip)
            field_err("reply_sender_ip", 64'(w.reply_sender_ip), 64'(g.reply_sender_ip));
        if (g.reply_target_mac !== w.reply_target_mac)
            field_err("reply_target_mac", 64'(w.reply_target_mac), 64'(g.reply_target_mac));
        if (g.reply_target_ip !== w.reply_target_ip)
            field_err("reply_target_ip", 64'(w.reply_target_ip), 64'(g.reply_target_ip));
        if (g.reply_htype !== w.reply_htype)
            field_err("reply_htype", 64'(w.reply_htype), 64'(g.reply_htype));
        if (g.reply_ptype !== w.reply_ptype)
            field_err("reply_ptype", 64'(w.reply_ptype), 64'(g.reply_ptype));
    endtask

    // predict on every accepted request word, check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                want = compute_answer(req_if.data);
                if (cur_given)
                    want = cur_given_rsp;
                pending_answers.push_back(want);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                n_answers++;
                if (pending_answers.size() == 0) begin
                    n_err++;
                    $display("%0t: result word with none expected, got %h", $time,
                             rsp_if.data);
                end else begin
                    check_answer(pending_answers.pop_front(), rsp_if.data);
                end
            end
        end
    end

    // result side: random stalls, one long hold-off while the sender keeps offering
    initial begin : rsp_sink
        int gap;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_no_idle = ~recv_no_idle;
            gap = recv_no_idle ? 0 : $urandom_range(0, 8);
            if (n_answers == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_IF0_IP:  if_ip[0]  = data[IP_W-1:0];
            CFG_IF0_MAC: if_mac[0] = data[MAC_W-1:0];
            CFG_IF1_IP:  if_ip[1]  = data[IP_W-1:0];
            CFG_IF1_MAC: if_mac[1] = data[MAC_W-1:0];
            CFG_IF2_IP:  if_ip[2]  = data[IP_W-1:0];
            CFG_IF2_MAC: if_mac[2] = data[MAC_W-1:0];
            CFG_IF_EN:   if_en     = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic set_iface(input int k, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac);
        write_reg(CFG_IP_IDX[k], {16'($urandom), ip});
        write_reg(CFG_MAC_IDX[k], mac);
    endtask

    task automatic set_enable(input logic [2:0] en);
        write_reg(CFG_IF_EN, {32'($urandom), 13'($urandom), en});
    endtask

    // offer one request word after a random gap
    task automatic push_req(input t_arp_req r, input logic given, input t_arp_rsp rsp);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_no_idle = ~send_no_idle;
        gap = send_no_idle ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.data   <= r;
        cur_given     = given;
        cur_given_rsp = rsp;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result word
    task automatic drain;
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_arp_req mk_lookup(input logic [IP_W-1:0] ip);
        t_arp_req r;
        r = '0;
        r.req_type  = REQ_LOOKUP;
        r.lookup_ip = ip;
        return r;
    endfunction

    function automatic t_arp_req mk_pkt(input logic [HALF_W-1:0] len,
                                        input logic [HALF_W-1:0] oper,
                                        input logic [MAC_W-1:0] smac,
                                        input logic [IP_W-1:0] sip,
                                        input logic [IP_W-1:0] tip);
        t_arp_req r;
        r = '0;
        r.req_type       = REQ_PACKET;
        r.pkt_len        = len;
        r.pkt_oper       = oper;
        r.pkt_htype      = HTYPE_ETH;
        r.pkt_ptype      = PTYPE_IPV4;
        r.pkt_sender_mac = smac;
        r.pkt_sender_ip  = sip;
        r.pkt_target_ip  = tip;
        return r;
    endfunction

    function automatic t_arp_rsp hit(input logic [MAC_W-1:0] mac);
        t_arp_rsp a;
        a = '0;
        a.lookup_hit = 1'b1;
        a.lookup_mac = mac;
        return a;
    endfunction

    // mostly well-formed packets and lookups on a small address pool
    function automatic t_arp_req rand_req();
        t_arp_req r;
        int       roll;
        roll = $urandom_range(0, 99);
        r.req_type  = (roll < 40) ? REQ_LOOKUP : REQ_PACKET;
        r.lookup_ip = pick_ip();
        roll = $urandom_range(0, 99);
        if (roll < 6)
            r.pkt_len = 16'($urandom_range(0, 27));
        else if (roll < 70)
            r.pkt_len = 16'($urandom_range(28, 64));
        else
            r.pkt_len = 16'($urandom_range(28, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 55)
            r.pkt_oper = OPER_REQUEST;
        else if (roll < 80)
            r.pkt_oper = OPER_REPLY;
        else
            r.pkt_oper = 16'($urandom);
        r.pkt_htype      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : HTYPE_ETH;
        r.pkt_ptype      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : PTYPE_IPV4;
        r.pkt_sender_mac = {16'($urandom), 32'($urandom)};
        r.pkt_sender_ip  = pick_ip();
        r.pkt_target_ip  = ($urandom_range(0, 9) < 6) ? if_ip[$urandom_range(0, N_IFACES - 1)]
                                                       : pick_ip();
        return r;
    endfunction

    // stimulus
    initial begin : stim
        t_row rows [$];
        logic [IP_W-1:0] shared_ip;

        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_wdata  = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;

        // predictor after reset
        for (int i = 0; i < N_ENTRIES; i++) begin
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
            tbl_valid[i] = 1'b0;
        end
        tbl_ip[0]    = E0_IP;
        tbl_mac[0]   = E0_MAC;
        tbl_valid[0] = 1'b1;
        for (int k = 0; k < CFG_IFACES; k++) begin
            if_ip[k]  = '0;
            if_mac[k] = '0;
        end
        if_en = '0;

        // address pool with the corner addresses in it
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        ip_pool[0] = E0_IP;
        ip_pool[1] = '0;
        ip_pool[2] = '1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed setup, including a write to the unused index
        write_reg(CFG_IDX_SPARE, '1);
        set_iface(0, 32'hC0A8_0001, 48'h0200_0000_0001);
        set_iface(1, 32'hC0A8_0002, 48'h0200_0000_0002);
        set_iface(2, 32'hC0A8_0003, 48'h0200_0000_0003);
        set_enable(3'b111);

        // reset entry, misses, short packets, non-request opcodes
        rows.push_back('{mk_lookup(E0_IP), 1'b1, hit(E0_MAC)});
        rows.push_back('{mk_lookup('0), 1'b1, NO_ANSWER});
        rows.push_back('{mk_lookup('1), 1'b1, NO_ANSWER});
        rows.push_back('{mk_pkt(16'd27, OPER_REQUEST, 48'h0A0B_0C0D_0E0F, 32'h0A00_0104,
                                32'hC0A8_0001), 1'b1, NO_ANSWER});
        rows.push_back('{mk_pkt(16'd0, OPER_REQUEST, 48'h0A0B_0C0D_0E0F, 32'h0A00_0104,
                                32'hC0A8_0001), 1'b1, NO_ANSWER});
        rows.push_back('{mk_lookup(32'h0A00_0104), 1'b1, NO_ANSWER});
        rows.push_back('{mk_pkt(MIN_ARP_LEN, OPER_REPLY, 48'h0000_5E00_0001, 32'h0A00_0105,
                                32'hC0A8_0001), 1'b1, NO_ANSWER});
        rows.push_back('{mk_lookup(32'h0A00_0105), 1'b1, hit(48'h0000_5E00_0001)});
        // requests answered by each interface
        rows.push_back('{mk_pkt(16'hFFFF, OPER_REQUEST, 48'hAABB_CCDD_EE01, 32'h0A00_0106,
                                32'hC0A8_0001), 1'b0, NO_ANSWER});
        rows.push_back('{mk_pkt(16'd60, OPER_REQUEST, 48'hAABB_CCDD_EE02, 32'h0A00_0107,
                                32'hC0A8_0002), 1'b0, NO_ANSWER});
        rows.push_back('{mk_pkt(16'd42, OPER_REQUEST, 48'hAABB_CCDD_EE03, 32'h0A00_0108,
                                32'hC0A8_0003), 1'b0, NO_ANSWER});
        // request for an address no interface owns
        rows.push_back('{mk_pkt(16'd28, OPER_REQUEST, 48'hAABB_CCDD_EE04, 32'h0A00_0109,
                                32'h0808_0808), 1'b1, NO_ANSWER});
        // opcode zero and all ones: learned but never answered
        rows.push_back('{mk_pkt(16'd28, 16'h0000, 48'h1111_2222_3333, 32'h0A00_0105,
                                32'hC0A8_0001), 1'b1, NO_ANSWER});
        rows.push_back('{mk_pkt(16'd28, 16'hFFFF, 48'h4444_5555_6666, 32'h0A00_0105,
                                32'hC0A8_0001), 1'b1, NO_ANSWER});
        rows.push_back('{mk_lookup(32'h0A00_0105), 1'b1, hit(48'h4444_5555_6666)});
        // all-ones fields
        rows.push_back('{mk_pkt(16'hFFFF, OPER_REQUEST, '1, '1, 32'hC0A8_0001), 1'b0,
                         NO_ANSWER});
        rows[$].req.pkt_htype = '1;
        rows[$].req.pkt_ptype = '1;
        rows.push_back('{mk_lookup('1), 1'b1, hit('1)});
        // zero mac and zero sender address
        rows.push_back('{mk_pkt(16'd28, OPER_REQUEST, '0, 32'h0A00_0106, '0), 1'b1,
                         NO_ANSWER});
        rows.push_back('{mk_lookup(32'h0A00_0106), 1'b1, hit('0)});
        rows.push_back('{mk_pkt(16'd28, OPER_REQUEST, 48'h0200_DEAD_BEEF, '0, 32'hC0A8_0002),
                         1'b0, NO_ANSWER});
        rows.push_back('{mk_lookup('0), 1'b0, NO_ANSWER});
        rows.push_back('{mk_lookup(E0_IP), 1'b1, hit(E0_MAC)});

        foreach (rows[i])
            push_req(rows[i].req, rows[i].given, rows[i].rsp);
        drain();

        // random phases, each under its own interface setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    for (int k = 0; k < CFG_IFACES; k++)
                        set_iface(k, ip_pool[$urandom_range(0, POOL_SIZE - 1)],
                                  {16'($urandom), 32'($urandom)});
                    set_enable(3'b111);
                end
                1: set_enable(3'b000);
                2: begin
                    set_iface(0, '0, '0);
                    set_iface(1, '1, '1);
                    set_iface(2, ip_pool[$urandom_range(3, POOL_SIZE - 1)],
                              {16'($urandom), 32'($urandom)});
                    set_enable(3'b111);
                end
                3: begin
                    // same address on all three, lowest enabled one must answer
                    shared_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
                    for (int k = 0; k < CFG_IFACES; k++)
                        set_iface(k, shared_ip, {16'($urandom), 32'($urandom)});
                    set_enable(3'b110);
                end
                default: begin
                    for (int k = 0; k < CFG_IFACES; k++)
                        set_iface(k, ip_pool[$urandom_range(0, POOL_SIZE - 1)],
                                  {16'($urandom), 32'($urandom)});
                    set_enable(3'($urandom_range(1, 7)));
                end
            endcase
            repeat (PHASE_WORDS)
                push_req(rand_req(), 1'b0, NO_ANSWER);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0 && pending_answers.size() == 0)
            $display("[arp_cache_and_responder_core] OK");
        else
            $display("[arp_cache_and_responder_core] ERROR");
        $finish;
    end

endmodule
